[rtl/rma_pkg.sv]
// Shared types and constants for the rounded moving average block.
// No dependencies; used by every module of the block and by the checker.
package rma_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MEAN_W     = 16;
  localparam int unsigned DEF_WINDOW = 30;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  // Status of the serial divider towards the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/rma_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rma_pkg for the status struct and the result width.
module rma_div #(
  parameter int unsigned DIVIDEND_W = 21,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [DIVIDEND_W-1:0]            dividend_i,
  input  logic [DIVISOR_W-1:0]             divisor_i,
  output logic [rma_pkg::MEAN_W-1:0]       quotient_o,
  output rma_pkg::div_stat_t               stat_o
);

  localparam int unsigned ITER_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] shreg_q, shreg_d;
  logic [DIVISOR_W:0]    rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvsr_q;
  logic [ITER_W-1:0]     iter_q, iter_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and trial-subtract
  assign rem_sh = {rem_q[DIVISOR_W-1:0], shreg_q[DIVIDEND_W-1]};
  assign fits   = rem_sh >= {1'b0, dvsr_q};

  always_comb begin
    shreg_d = shreg_q;
    rem_d   = rem_q;
    iter_d  = iter_q;
    busy_d  = busy_q;
    done_d  = done_q;
    if (start_i) begin
      shreg_d = dividend_i;
      rem_d   = '0;
      iter_d  = '0;
      busy_d  = 1'b1;
      done_d  = 1'b0;
    end else if (busy_q) begin
      rem_d   = fits ? (rem_sh - {1'b0, dvsr_q}) : rem_sh;
      shreg_d = {shreg_q[DIVIDEND_W-2:0], fits};
      iter_d  = iter_q + 1'b1;
      if (iter_q == ITER_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
    if (start_i) begin
      dvsr_q <= divisor_i;
    end
  end

  assign quotient_o  = shreg_q[rma_pkg::MEAN_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[rtl/rounded_moving_average.sv]
// Rounded sliding-window mean: sample ring, running sum and control.
// Depends on rma_pkg and rma_div.
//
// Usage: the slave stream carries one command per transaction; tuser selects
// add (0) or clear (1) and tdata carries the millivolt sample. An add writes
// the sample into a ring of WINDOW entries, updates the running sum and
// returns one transaction on the master stream holding the mean rounded to
// nearest. A clear empties the window in the cycle it is taken and returns
// nothing.
// Steps of an add: one ring read, one sum update, one divider load and the
// bit-serial divider, which produces one quotient bit per cycle. A new
// command is taken only once the result is loaded into the output register,
// so one add is in progress at a time.
// Reset clears the fill count, sum and write slot; ring contents are left
// undefined and are used only once every entry has been written.
// Back-pressure: the result waits in the output register; the next command
// is still accepted, but its result stays in the divider until the receiver
// takes the previous one.
module rounded_moving_average #(
  parameter int unsigned WINDOW = rma_pkg::DEF_WINDOW
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [rma_pkg::SAMPLE_W-1:0]     s_axis_tdata_i,  // [15:0] sample_mv
  input  logic                             s_axis_tuser_i,  // [0] cmd
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [rma_pkg::MEAN_W-1:0]       m_axis_tdata_o   // [15:0] mean_mv
);

  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = rma_pkg::SAMPLE_W + CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DIV    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [rma_pkg::SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [rma_pkg::SAMPLE_W-1:0] old_q;
  logic [rma_pkg::SAMPLE_W-1:0] sample_q;
  logic [SUM_W-1:0]             sum_q, sum_d;
  logic [CNT_W-1:0]             fill_q, fill_d;
  logic [SLOT_W-1:0]            slot_q, slot_d;
  logic [rma_pkg::MEAN_W-1:0]   mean_q;
  logic                         out_vld_q, out_vld_d;

  logic                         in_acc;
  logic                         out_free;
  logic                         ring_full;
  logic                         ring_we;
  logic                         div_start;
  logic                         div_start_q;
  logic                         div_done;
  logic [SUM_W-1:0]             dividend;
  logic [rma_pkg::MEAN_W-1:0]   quotient;
  rma_pkg::div_stat_t           div_stat;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign ring_full       = (fill_q == CNT_W'(WINDOW));
  assign ring_we         = (state_q == ST_UPDATE);
  assign dividend        = sum_q + SUM_W'(fill_q >> 1);
  // Ignore the done flag left over from the previous add while the load is pending
  assign div_done        = div_stat.done && !div_stat.busy && !div_start_q;

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    fill_d    = fill_q;
    slot_d    = slot_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (rma_pkg::cmd_e'(s_axis_tuser_i) == rma_pkg::CMD_CLEAR) begin
            sum_d  = '0;
            fill_d = '0;
            slot_d = '0;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        // Wait for the registered ring read of the slot about to be replaced
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        sum_d  = sum_q - (ring_full ? SUM_W'(old_q) : '0) + SUM_W'(sample_q);
        fill_d = ring_full ? fill_q : fill_q + 1'b1;
        slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done && out_free) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sum_q     <= '0;
      fill_q    <= '0;
      slot_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      fill_q    <= fill_d;
      slot_q    <= slot_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= s_axis_tdata_i;
    end
    if (state_q == ST_DIV && div_done && out_free) begin
      mean_q <= quotient;
    end
  end

  // Ring store: one write and one registered read at the current slot
  always_ff @(posedge clk_i) begin
    old_q <= ring_mem[slot_q];
    if (ring_we) begin
      ring_mem[slot_q] <= sample_q;
    end
  end

  // The start is registered, so the divider loads after the update and sees the new sum and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= div_start;
    end
  end

  rma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (dividend),
    .divisor_i  (fill_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = mean_q;

endmodule

[rtl/rma_checker.sv]
// Port-level checks for the rounded moving average block, bound to the top.
// Depends on rma_pkg for the command codes.
module rma_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_o,
  input  logic                         s_axis_tuser_i,
  input  logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  input  logic [rma_pkg::MEAN_W-1:0]   m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // An add occupies the block, so no second transaction follows at once
  a_add_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i == rma_pkg::CMD_ADD) |=> !s_axis_tready_o)
    else $error("command taken while an add is in progress");

  // A clear never produces a result
  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i == rma_pkg::CMD_CLEAR) && !m_axis_tvalid_o
      |=> !m_axis_tvalid_o)
    else $error("result after a clear");

endmodule

bind rounded_moving_average rma_checker u_rma_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[sim/tb.sv]
// Self-checking testbench for rounded_moving_average: directed and random commands
// on the slave stream, rounded window means checked on the master stream.
// Depends on rma_pkg and the rounded_moving_average RTL.
module tb;

  localparam int unsigned WINDOW   = rma_pkg::DEF_WINDOW;
  localparam int unsigned SAMPLE_W = rma_pkg::SAMPLE_W;
  localparam int unsigned MEAN_W   = rma_pkg::MEAN_W;
  localparam int unsigned SUM_W  = $clog2(WINDOW * (2**SAMPLE_W - 1) + 1);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int          N_RANDOM = 500;
  localparam int          TAIL_ITEMS = 50;

  typedef struct {
    rma_pkg::cmd_e       cmd;
    logic [SAMPLE_W-1:0] sample;
    bit                  drain;   // wait until every mean is out before sending
  } mv_cmd_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;
  rma_pkg::cmd_e       s_tuser = rma_pkg::CMD_ADD;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [MEAN_W-1:0]   m_tdata;

  mv_cmd_t           cmd_q[$];
  logic [MEAN_W-1:0] mean_q[$];
  int                mismatch_cnt = 0;

  // Own copy of the window state
  logic [SAMPLE_W-1:0] win_ring [WINDOW];
  logic [SUM_W-1:0]    win_sum = '0;
  logic [FILL_W-1:0]   win_fill = '0;
  logic [SLOT_W-1:0]   win_slot = '0;

  int src_gap = 0;
  bit src_idle_en = 1'b1;
  int snk_stall = 0;
  bit snk_idle_en = 1'b1;

  rounded_moving_average #(.WINDOW(WINDOW)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [15:0] sample_mv
    .s_axis_tuser_i  (s_tuser),   // [0] cmd
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // [15:0] mean_mv
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Update the window for one accepted command and queue the mean it gives
  task automatic advance_window(rma_pkg::cmd_e cmd, logic [SAMPLE_W-1:0] sample);
    logic [SUM_W:0] rounded;
    if (cmd == rma_pkg::CMD_CLEAR) begin
      win_sum  = '0;
      win_fill = '0;
      win_slot = '0;
    end else begin
      if (win_fill == FILL_W'(WINDOW))
        win_sum = win_sum - SUM_W'(win_ring[win_slot]);
      else
        win_fill = win_fill + 1'b1;
      win_ring[win_slot] = sample;
      win_sum  = win_sum + SUM_W'(sample);
      win_slot = (win_slot == SLOT_W'(WINDOW - 1)) ? '0 : win_slot + 1'b1;
      rounded  = ({1'b0, win_sum} + (SUM_W + 1)'(win_fill >> 1)) / (SUM_W + 1)'(win_fill);
      mean_q.push_back(rounded[MEAN_W-1:0]);
    end
  endtask

  task automatic queue_cmd(rma_pkg::cmd_e cmd, logic [SAMPLE_W-1:0] sample,
                           bit drain = 1'b0);
    mv_cmd_t item;
    item.cmd    = cmd;
    item.sample = sample;
    item.drain  = drain;
    cmd_q.push_back(item);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(int mode, logic [SAMPLE_W-1:0] base);
    case (mode)
      0:       return SAMPLE_W'($urandom);
      1:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      2:       return base ^ SAMPLE_W'($urandom_range(0, 15));
      default: return '1 - SAMPLE_W'($urandom_range(0, 3));
    endcase
  endfunction

  // Driver: present pending commands, predict on each transaction
  always @(posedge clk_i or negedge rst_ni) begin : drive
    mv_cmd_t item;
    bit      next_valid;
    bit      tail;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= rma_pkg::CMD_ADD;
    end else begin
      tail = (cmd_q.size() < TAIL_ITEMS);
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        advance_window(s_tuser, s_tdata);
        next_valid = 1'b0;
        if (src_idle_en && !tail && $urandom_range(0, 2) == 0)
          src_gap = $urandom_range(1, 4);
        if ($urandom_range(0, 49) == 0)
          src_idle_en = !src_idle_en;
      end
      if (!next_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (cmd_q.size() != 0 && (!cmd_q[0].drain || mean_q.size() == 0)) begin
          // chain another idle burst now and then
          if (src_idle_en && !tail && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 3);
          end else begin
            item = cmd_q.pop_front();
            next_valid = 1'b1;
            s_tdata <= item.sample;
            s_tuser <= item.cmd;
          end
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // Monitor: check each mean against the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin : observe
    logic [MEAN_W-1:0] want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (mean_q.size() == 0) begin
          $display("%0t: mean_mv expected none, got %0d", $time, m_tdata);
          mismatch_cnt++;
        end else begin
          want = mean_q.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: mean_mv expected %0d, got %0d", $time, want, m_tdata);
            mismatch_cnt++;
          end
        end
      end
      if (snk_stall > 0) begin
        snk_stall--;
        m_tready <= 1'b0;
      end else if (snk_idle_en && cmd_q.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        snk_stall = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0)
        snk_idle_en = !snk_idle_en;
    end
  end

  initial begin
    #2_000_000;
    $display("[rounded_moving_average] ERROR");
    $finish;
  end

  initial begin
    int                  n;
    int                  run_len;
    int                  mode;
    int                  wait_cnt;
    logic [SAMPLE_W-1:0] base;

    // Directed: extremes, rounding ties, clears on an empty window
    queue_cmd(rma_pkg::CMD_CLEAR, 16'hFFFF);
    queue_cmd(rma_pkg::CMD_ADD,   16'h0000);
    queue_cmd(rma_pkg::CMD_ADD,   16'hFFFF);
    queue_cmd(rma_pkg::CMD_ADD,   16'h0001);
    queue_cmd(rma_pkg::CMD_CLEAR, 16'h0000);
    queue_cmd(rma_pkg::CMD_ADD,   16'hFFFF);
    queue_cmd(rma_pkg::CMD_ADD,   16'hFFFF);
    queue_cmd(rma_pkg::CMD_ADD,   16'hFFFF);
    queue_cmd(rma_pkg::CMD_CLEAR, 16'h5A5A);
    queue_cmd(rma_pkg::CMD_CLEAR, 16'hA5A5);
    queue_cmd(rma_pkg::CMD_ADD,   16'h0001);
    queue_cmd(rma_pkg::CMD_ADD,   16'h0002);
    queue_cmd(rma_pkg::CMD_ADD,   16'h5555);
    queue_cmd(rma_pkg::CMD_ADD,   16'hAAAA);
    queue_cmd(rma_pkg::CMD_CLEAR, 16'h0000);
    queue_cmd(rma_pkg::CMD_ADD,   16'h0003, 1'b1);
    queue_cmd(rma_pkg::CMD_ADD,   16'h0000);
    queue_cmd(rma_pkg::CMD_ADD,   16'h8000);

    // Random: mostly long runs of adds that fill and wrap the ring, then clear
    n = 0;
    while (n < N_RANDOM) begin
      if ($urandom_range(0, 9) == 0) begin
        run_len = $urandom_range(0, 5);
        mode = 0;
      end else begin
        run_len = $urandom_range(WINDOW - 5, 3 * WINDOW);
        mode = $urandom_range(0, 3);
      end
      base = SAMPLE_W'($urandom);
      repeat (run_len) begin
        queue_cmd(rma_pkg::CMD_ADD, pick_sample(mode, base), $urandom_range(0, 39) == 0);
        n++;
      end
      queue_cmd(rma_pkg::CMD_CLEAR, SAMPLE_W'($urandom), $urandom_range(0, 9) == 0);
      n++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || s_tvalid) @(posedge clk_i);
    wait_cnt = 0;
    while (mean_q.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (40) @(posedge clk_i);

    if (mismatch_cnt == 0 && mean_q.size() == 0) begin
      $display("[rounded_moving_average] OK");
    end else begin
      $display("[rounded_moving_average] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rma_pkg.sv
rtl/rma_div.sv
rtl/rounded_moving_average.sv
rtl/rma_checker.sv
sim/tb.sv
